@@ rtl/core/bis_pkg.sv @@
// ---------------------------------------------------------------------------
// bis_pkg: shared constants and helpers of the bilinear image scaler
// Holds field widths, fixed-point formats, register indexes and the
// coordinate divider geometry.
// ---------------------------------------------------------------------------
package bis_pkg;

    // Image geometry
    localparam int MAX_SIDE   = 256;
    localparam int SIZE_W     = 9;      // size registers, 1..MAX_SIDE
    localparam int COORD_W    = 8;      // texel and pixel coordinates
    localparam int ADDR_W     = 16;     // texel store address
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int TEXEL_W    = 32;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = TEXEL_W / CHAN_W;
    localparam int NUM_NBR    = 4;

    // Fixed point
    localparam int FRAC_BITS  = 8;
    localparam int ONE_W      = FRAC_BITS + 1;
    localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;
    localparam int WGT_W      = 2 * FRAC_BITS + 1;      // up to ONE*ONE
    localparam int ACC_W      = CHAN_W + 2 * FRAC_BITS; // sum stays below 256*ONE*ONE

    // Coordinate divider: (t * src) fits 16 bits since t < 256 and src <= 256
    localparam int PROD_W     = 16;
    localparam int DVD_W      = PROD_W + FRAC_BITS;
    localparam int QSTEP      = 4;                      // quotient bits per cycle
    localparam int DIV_STEPS  = DVD_W / QSTEP;
    localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_H = 3'd3;

    // Item kinds on tuser
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // Map a written size onto 1..MAX_SIDE
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_SIDE)) begin
            r = SIZE_W'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/bis_div.sv @@
// ---------------------------------------------------------------------------
// bis_div: iterative unsigned divider for coordinate mapping
// Restoring division, QSTEP quotient bits per cycle, DIV_STEPS steps per
// quotient. The divisor must stay stable while the division runs.
// ---------------------------------------------------------------------------
module bis_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [bis_pkg::DVD_W-1:0]    i_dividend,
    input  logic [bis_pkg::SIZE_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [bis_pkg::DVD_W-1:0]    o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [bis_pkg::DCNT_W-1:0]    r_cnt;
    logic [bis_pkg::DVD_W-1:0]     r_dvd;
    logic [bis_pkg::DVD_W-1:0]     r_quo;
    logic [bis_pkg::SIZE_W-1:0]    r_rem;

    logic [bis_pkg::SIZE_W-1:0]    n_rem;
    logic [bis_pkg::QSTEP-1:0]     n_qbits;

    // Retire QSTEP quotient bits from the top of the dividend
    always_comb begin
        logic [bis_pkg::SIZE_W:0] trial;
        n_rem   = r_rem;
        n_qbits = '0;
        for (int i = 0; i < bis_pkg::QSTEP; i++) begin
            trial = {n_rem, r_dvd[bis_pkg::DVD_W-1-i]};
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = bis_pkg::SIZE_W'(trial - {1'b0, i_divisor});
                n_qbits[bis_pkg::QSTEP-1-i] = 1'b1;
            end else begin
                n_rem = trial[bis_pkg::SIZE_W-1:0];
            end
        end
    end

    // Step counter and shift registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= bis_pkg::DCNT_W'(bis_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == bis_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << bis_pkg::QSTEP;
            r_rem <= n_rem;
            r_quo <= {r_quo[bis_pkg::DVD_W-bis_pkg::QSTEP-1:0], n_qbits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ rtl/core/bilinear_image_scaler_top.sv @@
// ---------------------------------------------------------------------------
// bilinear_image_scaler_top: bilinear scaler over a loaded texel image
// Loads source texels into a single-port store and answers pixel requests
// with the bilinear blend of the four nearest source texels.
// ---------------------------------------------------------------------------
// A load item (tuser 0) writes one texel into the 65536-entry store and leaves
// the input open for the next item; it produces no result. A request item
// (tuser 1) goes from acceptance to its offered result through these steps:
// ST_PRE forms t*src, ST_DIV runs the coordinate dividers (six steps of four
// quotient bits and a completion flag), ST_MAP clamps, ST_MUL forms row bases
// and weights, ST_READ makes the four neighbor reads through the single memory
// port, and ST_FIN presents the pixel. The input stays closed for the whole
// request, so the next item is accepted only after the request is through; a
// result still waiting on the output holds the request in its last step until
// it is taken. Loads are taken while a result waits on the output. Store
// entries read before being loaded return undefined data. Size registers of 0
// act as 1 and values above 256 act as 256.
// ---------------------------------------------------------------------------
module bilinear_image_scaler_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [15:0] texel_index, [47:16] texel_value, [55:48] target_x, [63:56] target_y
    input  logic [63:0]          i_s_tdata,
    // [0] kind
    input  logic [0:0]           i_s_tuser,
    // master stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [31:0] pixel_value
    output logic [31:0]          o_m_tdata,
    // configuration write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [bis_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bis_pkg::SIZE_W-1:0]    i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_DIV,
        ST_MAP,
        ST_MUL,
        ST_READ,
        ST_FIN
    } t_state;

    typedef logic [bis_pkg::COORD_W-1:0] t_coord;

    t_state                          r_state;
    logic [bis_pkg::SIZE_W-1:0]      r_src_w, r_src_h, r_dst_w, r_dst_h;
    t_coord                          r_tx, r_ty;
    t_coord                          r_x0, r_x1, r_y0, r_y1;
    logic [bis_pkg::FRAC_BITS-1:0]   r_fx, r_fy;
    logic [bis_pkg::ADDR_W-1:0]      r_base0, r_base1;
    logic [bis_pkg::WGT_W-1:0]       r_w [bis_pkg::NUM_NBR];
    logic [bis_pkg::ACC_W-1:0]       r_acc [bis_pkg::NUM_CHAN];
    logic [2:0]                      r_k;
    logic                            r_out_valid;
    logic [bis_pkg::TEXEL_W-1:0]     r_out_data;

    logic [bis_pkg::TEXEL_W-1:0]     mem [bis_pkg::STORE_DEPTH];
    logic [bis_pkg::TEXEL_W-1:0]     r_rd_data;

    logic                            s_accept;
    logic                            mem_we;
    logic [bis_pkg::ADDR_W-1:0]      mem_addr;
    logic [bis_pkg::ADDR_W-1:0]      rd_addr;
    logic                            div_start;
    logic [bis_pkg::DVD_W-1:0]       dvd_x, dvd_y;
    logic                            done_x, done_y;
    logic [bis_pkg::DVD_W-1:0]       quo_x, quo_y;
    logic [bis_pkg::PROD_W-1:0]      pre_x, pre_y;
    logic [bis_pkg::ACC_W-1:0]       n_acc [bis_pkg::NUM_CHAN];
    logic [1:0]                      k_prev;
    t_coord                          last_x, last_y;

    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // Scale the destination coordinate by the source size
    assign pre_x  = bis_pkg::PROD_W'(r_tx) * bis_pkg::PROD_W'(r_src_w);
    assign pre_y  = bis_pkg::PROD_W'(r_ty) * bis_pkg::PROD_W'(r_src_h);
    assign dvd_x  = {pre_x, bis_pkg::FRAC_BITS'(0)};
    assign dvd_y  = {pre_y, bis_pkg::FRAC_BITS'(0)};
    assign div_start = (r_state == ST_PRE);

    bis_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd_x),
        .i_divisor  (r_dst_w),
        .o_done     (done_x),
        .o_quot     (quo_x)
    );

    bis_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd_y),
        .i_divisor  (r_dst_h),
        .o_done     (done_y),
        .o_quot     (quo_y)
    );

    assign last_x = bis_pkg::COORD_W'(r_src_w - 1'b1);
    assign last_y = bis_pkg::COORD_W'(r_src_h - 1'b1);

    // Pick the neighbor address for read slot r_k
    always_comb begin
        case (r_k[1:0])
            2'd0:    rd_addr = r_base0 + bis_pkg::ADDR_W'(r_x0);
            2'd1:    rd_addr = r_base0 + bis_pkg::ADDR_W'(r_x1);
            2'd2:    rd_addr = r_base1 + bis_pkg::ADDR_W'(r_x0);
            default: rd_addr = r_base1 + bis_pkg::ADDR_W'(r_x1);
        endcase
    end

    assign mem_we   = s_accept && (i_s_tuser[0] == bis_pkg::KIND_LOAD);
    assign mem_addr = mem_we ? i_s_tdata[15:0] : rd_addr;

    // Texel store, single port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= i_s_tdata[47:16];
        end
        r_rd_data <= mem[mem_addr];
    end

    // Weighted accumulate of the texel read in the previous slot
    assign k_prev = 2'(r_k - 1'b1);
    always_comb begin
        for (int c = 0; c < bis_pkg::NUM_CHAN; c++) begin
            n_acc[c] = r_acc[c] +
                bis_pkg::ACC_W'(r_rd_data[c*bis_pkg::CHAN_W +: bis_pkg::CHAN_W]) *
                bis_pkg::ACC_W'(r_w[k_prev]);
        end
    end

    // Sequencer, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_src_w     <= bis_pkg::SIZE_W'(bis_pkg::MAX_SIDE);
            r_src_h     <= bis_pkg::SIZE_W'(bis_pkg::MAX_SIDE);
            r_dst_w     <= bis_pkg::SIZE_W'(bis_pkg::MAX_SIDE);
            r_dst_h     <= bis_pkg::SIZE_W'(bis_pkg::MAX_SIDE);
        end else begin
            // hold effective sizes
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    bis_pkg::CFG_SRC_W: r_src_w <= bis_pkg::eff_size(i_cfg_data);
                    bis_pkg::CFG_SRC_H: r_src_h <= bis_pkg::eff_size(i_cfg_data);
                    bis_pkg::CFG_DST_W: r_dst_w <= bis_pkg::eff_size(i_cfg_data);
                    bis_pkg::CFG_DST_H: r_dst_h <= bis_pkg::eff_size(i_cfg_data);
                    default: ;
                endcase
            end

            // drop a result once taken, unless a new one replaces it
            if (r_out_valid && i_m_tready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_accept && (i_s_tuser[0] == bis_pkg::KIND_REQUEST)) begin
                        r_tx    <= i_s_tdata[55:48];
                        r_ty    <= i_s_tdata[63:56];
                        r_state <= ST_PRE;
                    end
                end
                ST_PRE: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (done_x && done_y) begin
                        r_state <= ST_MAP;
                    end
                end
                ST_MAP: begin
                    // clamp on the last column and row
                    if (quo_x[bis_pkg::DVD_W-1:bis_pkg::FRAC_BITS] >=
                        (bis_pkg::DVD_W-bis_pkg::FRAC_BITS)'(last_x)) begin
                        r_x0 <= last_x;
                        r_x1 <= last_x;
                        r_fx <= '0;
                    end else begin
                        r_x0 <= quo_x[bis_pkg::FRAC_BITS +: bis_pkg::COORD_W];
                        r_x1 <= quo_x[bis_pkg::FRAC_BITS +: bis_pkg::COORD_W] + 1'b1;
                        r_fx <= quo_x[bis_pkg::FRAC_BITS-1:0];
                    end
                    if (quo_y[bis_pkg::DVD_W-1:bis_pkg::FRAC_BITS] >=
                        (bis_pkg::DVD_W-bis_pkg::FRAC_BITS)'(last_y)) begin
                        r_y0 <= last_y;
                        r_y1 <= last_y;
                        r_fy <= '0;
                    end else begin
                        r_y0 <= quo_y[bis_pkg::FRAC_BITS +: bis_pkg::COORD_W];
                        r_y1 <= quo_y[bis_pkg::FRAC_BITS +: bis_pkg::COORD_W] + 1'b1;
                        r_fy <= quo_y[bis_pkg::FRAC_BITS-1:0];
                    end
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    // row bases and the four weights
                    r_base0 <= bis_pkg::ADDR_W'(r_y0) * bis_pkg::ADDR_W'(r_src_w);
                    r_base1 <= bis_pkg::ADDR_W'(r_y1) * bis_pkg::ADDR_W'(r_src_w);
                    r_w[0]  <= bis_pkg::WGT_W'(bis_pkg::ONE - r_fx) *
                               bis_pkg::WGT_W'(bis_pkg::ONE - r_fy);
                    r_w[1]  <= bis_pkg::WGT_W'(r_fx) *
                               bis_pkg::WGT_W'(bis_pkg::ONE - r_fy);
                    r_w[2]  <= bis_pkg::WGT_W'(bis_pkg::ONE - r_fx) *
                               bis_pkg::WGT_W'(r_fy);
                    r_w[3]  <= bis_pkg::WGT_W'(r_fx) * bis_pkg::WGT_W'(r_fy);
                    for (int c = 0; c < bis_pkg::NUM_CHAN; c++) begin
                        r_acc[c] <= '0;
                    end
                    r_k     <= '0;
                    r_state <= ST_READ;
                end
                ST_READ: begin
                    // issue reads in slots 0..3, accumulate one slot behind
                    if (r_k != 3'd0) begin
                        for (int c = 0; c < bis_pkg::NUM_CHAN; c++) begin
                            r_acc[c] <= n_acc[c];
                        end
                    end
                    if (r_k == 3'(bis_pkg::NUM_NBR)) begin
                        r_state <= ST_FIN;
                    end
                    r_k <= r_k + 1'b1;
                end
                ST_FIN: begin
                    // wait for a free output register
                    if (!r_out_valid || i_m_tready) begin
                        for (int c = 0; c < bis_pkg::NUM_CHAN; c++) begin
                            r_out_data[c*bis_pkg::CHAN_W +: bis_pkg::CHAN_W] <=
                                r_acc[c][bis_pkg::ACC_W-1 -: bis_pkg::CHAN_W];
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
